// ===== rtl/rqsd_pkg.sv =====
// Shared types, constants and helpers for the ready queue with search and delete.
package rqsd_pkg;

   // Queue geometry
   localparam int DEPTH    = 16;
   localparam int ID_WIDTH = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   // Fixed field widths of the transfer payloads
   localparam int CMD_W     = 3;
   localparam int ITEM_ID_W = 16;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef logic [ID_WIDTH-1:0] id_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [ITEM_ID_W-1:0] item_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ITEM_ID_W-1:0] out_id;
      logic [OCC_W-1:0]     occupancy;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                latch;      // capture the request id
      logic                push_wr;    // append the request id
      logic                rd_head;    // read the oldest entry
      logic                pop_adv;    // drop the oldest entry
      logic                srch_start; // begin search at the newest entry
      logic                srch_step;  // advance search by one entry
      logic                sh_start;   // begin closing the gap at the hit
      logic                sh_step;    // advance the gap close by one entry
      logic                sh_finish;  // drop the removed entry from the count
      logic                rsp_load;   // load the result register
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_data;   // return the read entry as out_id
   } ctl_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic empty;
      logic full;
      logic srch_hit;
      logic srch_miss;
      logic sh_done;
   } sts_type;

   // Map the 16-bit id field onto the stored id width
   function automatic id_type to_id(logic [ITEM_ID_W-1:0] f);
      logic [63:0] w;
      w = 64'(f);
      return w[ID_WIDTH-1:0];
   endfunction

   // Map a stored id back onto the 16-bit id field
   function automatic logic [ITEM_ID_W-1:0] from_id(id_type v);
      logic [63:0] w;
      w = 64'(v);
      return w[ITEM_ID_W-1:0];
   endfunction

endpackage

// ===== rtl/rqsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rqsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rqsd_ctrl.sv =====
// Controller state machine sequencing each queue command.
module rqsd_ctrl import rqsd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] cmd,
   input  sts_type          sts,
   output ctl_type          ctl,
   output logic             busy
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_OLD,
      S_SEARCH,
      S_SHIFT
   } state_type;

   state_type state_ff, state_in;
   logic      is_pop_ff, is_pop_in;
   logic      is_remove_ff, is_remove_in;

   // Decode the next step from state, request and datapath status
   always_comb begin
      ctl          = '0;
      state_in     = state_ff;
      is_pop_in    = is_pop_ff;
      is_remove_in = is_remove_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               unique case (cmd)
                  CMD_PUSH: begin
                     ctl.rsp_load = 1'b1;
                     if (sts.full) begin
                        ctl.rsp_status = ST_FULL;
                     end else begin
                        ctl.push_wr    = 1'b1;
                        ctl.rsp_status = ST_OK;
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (sts.empty) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_status = ST_MISS;
                     end else begin
                        ctl.rd_head = 1'b1;
                        is_pop_in   = (cmd == CMD_POP);
                        state_in    = S_OLD;
                     end
                  end
                  CMD_QUERY, CMD_REMOVE: begin
                     if (sts.empty) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_status = ST_MISS;
                     end else begin
                        ctl.srch_start = 1'b1;
                        is_remove_in   = (cmd == CMD_REMOVE);
                        state_in       = S_SEARCH;
                     end
                  end
                  default: begin
                     ctl.rsp_load   = 1'b1;
                     ctl.rsp_status = ST_OK;
                  end
               endcase
            end
         end
         S_OLD: begin
            ctl.rsp_load   = 1'b1;
            ctl.rsp_status = ST_OK;
            ctl.rsp_data   = 1'b1;
            ctl.pop_adv    = is_pop_ff;
            state_in       = S_IDLE;
         end
         S_SEARCH: begin
            ctl.srch_step = 1'b1;
            priority if (sts.srch_hit) begin
               if (is_remove_ff) begin
                  ctl.sh_start = 1'b1;
                  state_in     = S_SHIFT;
               end else begin
                  ctl.rsp_load   = 1'b1;
                  ctl.rsp_status = ST_OK;
                  state_in       = S_IDLE;
               end
            end else if (sts.srch_miss) begin
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = ST_MISS;
               state_in       = S_IDLE;
            end
         end
         S_SHIFT: begin
            ctl.sh_step = 1'b1;
            if (sts.sh_done) begin
               ctl.sh_finish  = 1'b1;
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = ST_OK;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and command flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         is_pop_ff    <= 1'b0;
         is_remove_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_pop_ff    <= is_pop_in;
         is_remove_ff <= is_remove_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/rqsd_dpath.sv =====
// Datapath: circular slot store, pointers, search and gap-close sequencing, result register.
module rqsd_dpath import rqsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  ctl_type ctl,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp
);

   typedef logic [CNT_W:0] sum_type;

   idx_type head_ff, head_in;
   cnt_type cnt_ff, cnt_in;
   id_type  id_ff;

   cnt_type srch_idx_ff, srch_idx_in;
   logic    srch_more_ff, srch_more_in;
   logic    srch_pend_ff, srch_pend_in;
   cnt_type pend_idx_ff, pend_idx_in;

   cnt_type sh_rd_ff, sh_rd_in;
   cnt_type sh_wr_ff, sh_wr_in;
   logic    sh_pend_ff, sh_pend_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic    wr_en;
   idx_type wr_addr;
   id_type  wr_data;
   idx_type rd_addr;
   id_type  rd_data;

   // Physical slot of the entry at a given age rank above the oldest
   function automatic idx_type phys(idx_type base, cnt_type k);
      sum_type s;
      s = sum_type'(base) + sum_type'(k);
      if (s >= sum_type'(DEPTH)) begin
         s = s - sum_type'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   rqsd_ram #(
      .WIDTH(ID_WIDTH),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Select the read address
   always_comb begin
      priority if (ctl.rd_head) begin
         rd_addr = head_ff;
      end else if (ctl.sh_step) begin
         rd_addr = phys(head_ff, sh_rd_ff);
      end else begin
         rd_addr = phys(head_ff, srch_idx_ff);
      end
   end

   // Select the write: append on push, move down while closing a gap
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = phys(head_ff, cnt_ff);
      wr_data = to_id(req.item_id);
      priority if (ctl.push_wr) begin
         wr_en = 1'b1;
      end else if (ctl.sh_step && sh_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, sh_wr_ff);
         wr_data = rd_data;
      end
   end

   // Advance head pointer and fill count
   always_comb begin
      head_in = head_ff;
      cnt_in  = cnt_ff;
      if (ctl.pop_adv) begin
         head_in = (head_ff == idx_type'(DEPTH - 1)) ? '0 : head_ff + idx_type'(1);
      end
      priority if (ctl.push_wr) begin
         cnt_in = cnt_ff + cnt_type'(1);
      end else if (ctl.pop_adv || ctl.sh_finish) begin
         cnt_in = cnt_ff - cnt_type'(1);
      end
   end

   // Search from newest to oldest, one read issued per cycle
   always_comb begin
      srch_idx_in  = srch_idx_ff;
      srch_more_in = srch_more_ff;
      srch_pend_in = 1'b0;
      pend_idx_in  = pend_idx_ff;
      if (ctl.srch_start) begin
         srch_idx_in  = cnt_ff - cnt_type'(1);
         srch_more_in = 1'b1;
      end else if (ctl.srch_step && srch_more_ff) begin
         srch_pend_in = 1'b1;
         pend_idx_in  = srch_idx_ff;
         srch_more_in = (srch_idx_ff != '0);
         srch_idx_in  = srch_idx_ff - cnt_type'(1);
      end
   end

   // Close the gap: read the entry above, write it one place down once its read data returns
   always_comb begin
      sh_rd_in   = sh_rd_ff;
      sh_wr_in   = sh_wr_ff;
      sh_pend_in = 1'b0;
      if (ctl.sh_start) begin
         sh_rd_in = pend_idx_ff + cnt_type'(1);
      end else if (ctl.sh_step && (sh_rd_ff < cnt_ff)) begin
         sh_pend_in = 1'b1;
         sh_wr_in   = sh_rd_ff - cnt_type'(1);
         sh_rd_in   = sh_rd_ff + cnt_type'(1);
      end
   end

   // Status toward the controller
   always_comb begin
      sts.empty     = (cnt_ff == '0);
      sts.full      = (cnt_ff == cnt_type'(DEPTH));
      sts.srch_hit  = srch_pend_ff && (rd_data == id_ff);
      sts.srch_miss = srch_pend_ff && (rd_data != id_ff) && (pend_idx_ff == '0);
      sts.sh_done   = (sh_rd_ff >= cnt_ff) && !sh_pend_ff;
   end

   // Build the result
   always_comb begin
      rsp_in.status    = ctl.rsp_status;
      rsp_in.out_id    = ctl.rsp_data ? from_id(rd_data) : '0;
      rsp_in.occupancy = OCC_W'(cnt_in);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         cnt_ff       <= '0;
         srch_more_ff <= 1'b0;
         srch_pend_ff <= 1'b0;
         sh_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         srch_more_ff <= srch_more_in;
         srch_pend_ff <= srch_pend_in;
         sh_pend_ff   <= sh_pend_in;
         rsp_valid_ff <= ctl.rsp_load;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         id_ff <= to_id(req.item_id);
      end
      srch_idx_ff <= srch_idx_in;
      pend_idx_ff <= pend_idx_in;
      sh_rd_ff    <= sh_rd_in;
      sh_wr_ff    <= sh_wr_in;
      if (ctl.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/ready_queue_with_search_delete_unit.sv =====
// Top level of the ready queue with search and delete.
//
// A command is taken when start is high and busy is low; its single result appears on
// rsp_item for exactly one cycle, flagged by rsp_valid, and must be captured then, since
// the receiver cannot stall it. Push, any command on an empty queue and unused codes
// answer in the cycle after the transfer and leave busy low. Pop and peek answer after
// one registered read of the slot RAM. Query scans from the newest entry
// toward the oldest through the single RAM read port, one entry per cycle, and
// answers on the first match or, after the oldest entry, with a miss. Remove then
// closes the gap, moving each newer entry one place down once its read data returns.
// Entries live in a circular RAM, so pop needs no data movement.
module ready_queue_with_search_delete_unit import rqsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   ctl_type ctl;
   sts_type sts;

   rqsd_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .cmd  (req_item.cmd),
      .sts  (sts),
      .ctl  (ctl),
      .busy (busy)
   );

   rqsd_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req      (req_item),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp      (rsp_item)
   );

endmodule
